// ----- src/matrix3x3_inverse_core_defines.svh -----
// Assertion macros shared by the matrix inverse RTL.
`ifndef MATRIX3X3_INVERSE_CORE_DEFINES_SVH
`define MATRIX3X3_INVERSE_CORE_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define M3I_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// A condition that, when true, forces another one on the following edge.
`define M3I_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ----- src/m3i_pkg.sv -----
// Shared constants and index tables for the 3x3 matrix inverse.
package m3i_pkg;

  // Number of matrix elements per item.
  localparam int unsigned NUM_ELEM = 9;
  // Number of terms in the determinant expansion along the first column.
  localparam int unsigned NUM_DET = 3;

  typedef logic [3:0] elem_idx_t;

  // Cofactor k is e[COF_A]*e[COF_B] - e[COF_C]*e[COF_D], row-major elements.
  localparam elem_idx_t COF_A [NUM_ELEM] = '{4'd4, 4'd2, 4'd1, 4'd5, 4'd0, 4'd2, 4'd3, 4'd1, 4'd0};
  localparam elem_idx_t COF_B [NUM_ELEM] = '{4'd8, 4'd7, 4'd5, 4'd6, 4'd8, 4'd3, 4'd7, 4'd6, 4'd4};
  localparam elem_idx_t COF_C [NUM_ELEM] = '{4'd5, 4'd1, 4'd2, 4'd3, 4'd2, 4'd0, 4'd4, 4'd0, 4'd1};
  localparam elem_idx_t COF_D [NUM_ELEM] = '{4'd7, 4'd8, 4'd4, 4'd8, 4'd6, 4'd5, 4'd6, 4'd7, 4'd3};

  // The determinant is sum of e[DET_ROW[j]] * cofactor j for j = 0..2.
  localparam elem_idx_t DET_ROW [NUM_DET] = '{4'd0, 4'd3, 4'd6};

endpackage

// ----- src/m3i_front.sv -----
// Front pipeline: pair products, cofactors and the exact determinant.
module m3i_front #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic signed [DATA_WIDTH-1:0]     in_elem_i [m3i_pkg::NUM_ELEM],
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [DATA_WIDTH-1:0]     out_elem_o [m3i_pkg::NUM_ELEM],
  output logic signed [2*DATA_WIDTH:0]     out_cof_o [m3i_pkg::NUM_ELEM],
  output logic signed [3*DATA_WIDTH+2:0]   out_det_o,
  output logic                             out_sing_o
);
  import m3i_pkg::*;

  localparam int unsigned W  = DATA_WIDTH;
  localparam int unsigned PW = 2 * W;
  localparam int unsigned CW = 2 * W + 1;
  localparam int unsigned DW = 3 * W + 3;

  logic v0_q, v1_q, v2_q, v3_q, v4_q;
  logic en;

  logic signed [W-1:0]  e0_q [NUM_ELEM];
  logic signed [W-1:0]  e1_q [NUM_ELEM];
  logic signed [W-1:0]  e2_q [NUM_ELEM];
  logic signed [W-1:0]  e3_q [NUM_ELEM];
  logic signed [W-1:0]  e4_q [NUM_ELEM];
  logic signed [PW-1:0] pab_d [NUM_ELEM];
  logic signed [PW-1:0] pab_q [NUM_ELEM];
  logic signed [PW-1:0] pcd_d [NUM_ELEM];
  logic signed [PW-1:0] pcd_q [NUM_ELEM];
  logic signed [CW-1:0] cof_d [NUM_ELEM];
  logic signed [CW-1:0] cof1_q [NUM_ELEM];
  logic signed [CW-1:0] cof2_q [NUM_ELEM];
  logic signed [CW-1:0] cof3_q [NUM_ELEM];
  logic signed [CW-1:0] cof4_q [NUM_ELEM];
  logic signed [CW-1:0] plo_d [NUM_DET];
  logic signed [CW-1:0] plo_q [NUM_DET];
  logic signed [CW-1:0] phi_d [NUM_DET];
  logic signed [CW-1:0] phi_q [NUM_DET];
  logic signed [DW-1:0] t_d [NUM_DET];
  logic signed [DW-1:0] t_q [NUM_DET];
  logic signed [DW-1:0] det_d;
  logic signed [DW-1:0] det_q;

  // The whole front moves together unless its last item is held.
  assign en         = !v4_q || out_ready_i;
  assign in_ready_o = en;

  // Arithmetic of each stage.
  always_comb begin
    for (int k = 0; k < NUM_ELEM; k++) begin
      pab_d[k] = in_elem_i[COF_A[k]] * in_elem_i[COF_B[k]];
      pcd_d[k] = in_elem_i[COF_C[k]] * in_elem_i[COF_D[k]];
      cof_d[k] = CW'(pab_q[k]) - CW'(pcd_q[k]);
    end
    // Each cofactor is split into a signed high half and an unsigned low half.
    for (int j = 0; j < NUM_DET; j++) begin
      plo_d[j] = e1_q[DET_ROW[j]] * $signed({1'b0, cof1_q[j][W-1:0]});
      phi_d[j] = e1_q[DET_ROW[j]] * $signed(cof1_q[j][CW-1:W]);
      t_d[j]   = (DW'(phi_q[j]) <<< W) + DW'(plo_q[j]);
    end
    det_d = t_q[0] + t_q[1] + t_q[2];
  end

  // Stage valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en) begin
      v0_q <= in_valid_i;
      v1_q <= v0_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // Stage payload.
  always_ff @(posedge clk_i) begin
    if (en) begin
      e0_q   <= in_elem_i;
      pab_q  <= pab_d;
      pcd_q  <= pcd_d;
      e1_q   <= e0_q;
      cof1_q <= cof_d;
      e2_q   <= e1_q;
      cof2_q <= cof1_q;
      plo_q  <= plo_d;
      phi_q  <= phi_d;
      e3_q   <= e2_q;
      cof3_q <= cof2_q;
      t_q    <= t_d;
      e4_q   <= e3_q;
      cof4_q <= cof3_q;
      det_q  <= det_d;
    end
  end

  // Classification: a zero determinant marks the item singular.
  assign out_valid_o = v4_q;
  assign out_elem_o  = e4_q;
  assign out_cof_o   = cof4_q;
  assign out_det_o   = det_q;
  assign out_sing_o  = (det_q == '0);

  `include "matrix3x3_inverse_core_defines.svh"

  `M3I_ASSERT_NEXT(a_front_hold, v4_q && !out_ready_i, v4_q && $stable(det_q), "front item lost while held")

endmodule

// ----- src/m3i_queue.sv -----
// Short register queue between the front and the back.
module m3i_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);
  import m3i_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [CNTW-1:0]  cnt_q, cnt_d;
  logic             push, pop;

  assign push_ready_o = (cnt_q != CNTW'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Pointer and fill count update.
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop) begin
      rd_d = (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  `include "matrix3x3_inverse_core_defines.svh"

  `M3I_ASSERT_ALWAYS(a_queue_count, cnt_q <= CNTW'(DEPTH), "queue count beyond depth")

endmodule

// ----- src/m3i_back.sv -----
// Back pipeline: nine pipelined dividers by the determinant, saturation.
module m3i_back #(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic signed [DATA_WIDTH-1:0]   in_elem_i [m3i_pkg::NUM_ELEM],
  input  logic signed [2*DATA_WIDTH:0]   in_cof_i [m3i_pkg::NUM_ELEM],
  input  logic signed [3*DATA_WIDTH+2:0] in_det_i,
  input  logic                           in_sing_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [DATA_WIDTH-1:0]   out_elem_o [m3i_pkg::NUM_ELEM],
  output logic                           out_sing_o
);
  import m3i_pkg::*;

  localparam int unsigned W  = DATA_WIDTH;
  localparam int unsigned CW = 2 * W + 1;
  localparam int unsigned DW = 3 * W + 3;
  localparam int unsigned NW = CW + 2 * FRAC_BITS;
  localparam int unsigned RW = (NW > DW + W) ? NW : DW + W;
  // Setup stage, overflow check, then one stage per quotient bit.
  localparam int unsigned NS = W + 2;
  localparam logic [W-1:0] HALF = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};

  logic                en;
  logic                v_q    [NS];
  logic                sing_d [NS];
  logic                sing_q [NS];
  logic signed [W-1:0] e_d    [NS][NUM_ELEM];
  logic signed [W-1:0] e_q    [NS][NUM_ELEM];
  logic [DW-1:0]       dm_d   [NS];
  logic [DW-1:0]       dm_q   [NS];
  logic [RW-1:0]       rem_d  [NS][NUM_ELEM];
  logic [RW-1:0]       rem_q  [NS][NUM_ELEM];
  logic [W-1:0]        quo_d  [NS][NUM_ELEM];
  logic [W-1:0]        quo_q  [NS][NUM_ELEM];
  logic                neg_d  [NS][NUM_ELEM];
  logic                neg_q  [NS][NUM_ELEM];
  logic                ovf_d  [NS][NUM_ELEM];
  logic                ovf_q  [NS][NUM_ELEM];

  logic                out_v_q;
  logic                out_sing_q;
  logic signed [W-1:0] out_e_d [NUM_ELEM];
  logic signed [W-1:0] out_e_q [NUM_ELEM];

  // The back moves as one unless the output register is held.
  assign en         = !out_v_q || out_ready_i;
  assign in_ready_o = en;

  // Stage logic for all nine lanes.
  always_comb begin
    logic [CW-1:0] cmag;
    logic [RW-1:0] dsh;
    logic          det_neg;
    // Setup: magnitudes, result signs and the shifted numerator.
    det_neg   = in_det_i[DW-1];
    dm_d[0]   = det_neg ? (~in_det_i + 1'b1) : in_det_i;
    sing_d[0] = in_sing_i;
    e_d[0]    = in_elem_i;
    for (int k = 0; k < NUM_ELEM; k++) begin
      cmag          = in_cof_i[k][CW-1] ? (~in_cof_i[k] + 1'b1) : in_cof_i[k];
      rem_d[0][k]   = {{(RW-CW){1'b0}}, cmag} << (2 * FRAC_BITS);
      neg_d[0][k]   = in_cof_i[k][CW-1] ^ det_neg;
      quo_d[0][k]   = '0;
      ovf_d[0][k]   = 1'b0;
    end
    // Carry everything forward by default.
    for (int s = 1; s < NS; s++) begin
      sing_d[s] = sing_q[s-1];
      e_d[s]    = e_q[s-1];
      dm_d[s]   = dm_q[s-1];
      rem_d[s]  = rem_q[s-1];
      quo_d[s]  = quo_q[s-1];
      neg_d[s]  = neg_q[s-1];
      ovf_d[s]  = ovf_q[s-1];
    end
    // A quotient of 2^W or more saturates in either sign.
    dsh = {{(RW-DW){1'b0}}, dm_q[0]} << W;
    for (int k = 0; k < NUM_ELEM; k++) begin
      ovf_d[1][k] = (rem_q[0][k] >= dsh);
    end
    // Restoring division, one quotient bit per stage, high bit first.
    for (int s = 2; s < NS; s++) begin
      dsh = {{(RW-DW){1'b0}}, dm_q[s-1]} << (W + 1 - s);
      for (int k = 0; k < NUM_ELEM; k++) begin
        if (rem_q[s-1][k] >= dsh) begin
          rem_d[s][k]             = rem_q[s-1][k] - dsh;
          quo_d[s][k][W + 1 - s]  = 1'b1;
        end
      end
    end
    // Saturate to the element range, or pass the input through when singular.
    for (int k = 0; k < NUM_ELEM; k++) begin
      if (sing_q[NS-1]) begin
        out_e_d[k] = e_q[NS-1][k];
      end else if (neg_q[NS-1][k]) begin
        if (ovf_q[NS-1][k] || (quo_q[NS-1][k] > HALF)) begin
          out_e_d[k] = HALF;
        end else begin
          out_e_d[k] = ~quo_q[NS-1][k] + 1'b1;
        end
      end else if (ovf_q[NS-1][k] || (quo_q[NS-1][k] > MAXV)) begin
        out_e_d[k] = MAXV;
      end else begin
        out_e_d[k] = quo_q[NS-1][k];
      end
    end
  end

  // Valid bits of the stages and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NS; s++) begin
        v_q[s] <= 1'b0;
      end
      out_v_q <= 1'b0;
    end else if (en) begin
      v_q[0] <= in_valid_i;
      for (int s = 1; s < NS; s++) begin
        v_q[s] <= v_q[s-1];
      end
      out_v_q <= v_q[NS-1];
    end
  end

  // Stage payload.
  always_ff @(posedge clk_i) begin
    if (en) begin
      sing_q     <= sing_d;
      e_q        <= e_d;
      dm_q       <= dm_d;
      rem_q      <= rem_d;
      quo_q      <= quo_d;
      neg_q      <= neg_d;
      ovf_q      <= ovf_d;
      out_e_q    <= out_e_d;
      out_sing_q <= sing_q[NS-1];
    end
  end

  assign out_valid_o = out_v_q;
  assign out_elem_o  = out_e_q;
  assign out_sing_o  = out_sing_q;

  `include "matrix3x3_inverse_core_defines.svh"

  `M3I_ASSERT_NEXT(a_sing_pass, en && v_q[NS-1] && sing_q[NS-1], out_sing_q && (out_e_q[0] == $past(e_q[NS-1][0])), "singular item not passed through")
  `M3I_ASSERT_NEXT(a_pos_sat, en && v_q[NS-1] && !sing_q[NS-1] && ovf_q[NS-1][0] && !neg_q[NS-1][0], out_e_q[0] == MAXV, "overflow did not saturate")

endmodule

// ----- src/matrix3x3_inverse_core.sv -----
// Top level of the 3x3 matrix inverse: front, queue and divider back end.
//
// Accepts one 3x3 matrix of signed fixed-point elements per clock and returns
// its inverse, one matrix per clock, in order, while neither side stalls. The
// determinant and the nine cofactors are formed exactly; each output is
// cofactor * 2^(2*FRAC_BITS) divided by the determinant, truncated toward
// zero and saturated. A zero determinant returns the input matrix unchanged
// with tuser set. An item passes the product and sum stages of the front,
// the two-entry queue, and the stages of the back, whose restoring dividers
// resolve one quotient bit per pipeline stage. Either side may stall without
// blocking the other while the queue has room.
module matrix3x3_inverse_core #(
  parameter int unsigned FRAC_BITS  = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // in_r1c1, in_r1c2, in_r1c3, in_r2c1 .. in_r3c3, zero padded to bytes
  input  logic [((9*DATA_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // out_r1c1, out_r1c2, out_r1c3, out_r2c1 .. out_r3c3, zero padded to bytes
  output logic [((9*DATA_WIDTH+7)/8)*8-1:0] m_axis_tdata,
  // singular
  output logic [0:0] m_axis_tuser
);
  import m3i_pkg::*;

  localparam int unsigned W  = DATA_WIDTH;
  localparam int unsigned CW = 2 * W + 1;
  localparam int unsigned DW = 3 * W + 3;
  localparam int unsigned CO = NUM_ELEM * W;
  localparam int unsigned DO = CO + NUM_ELEM * CW;
  localparam int unsigned QW = DO + DW + 1;

  logic signed [W-1:0]  in_e [NUM_ELEM];
  logic                 f_valid, f_ready, f_sing;
  logic signed [W-1:0]  f_e [NUM_ELEM];
  logic signed [CW-1:0] f_cof [NUM_ELEM];
  logic signed [DW-1:0] f_det;
  logic [QW-1:0]        q_in, q_out;
  logic                 b_valid, b_ready;
  logic signed [W-1:0]  b_e [NUM_ELEM];
  logic signed [CW-1:0] b_cof [NUM_ELEM];
  logic signed [DW-1:0] b_det;
  logic                 b_sing;
  logic signed [W-1:0]  o_e [NUM_ELEM];
  logic                 o_sing;

  // Unpack and pack the stream words and the queue entry.
  always_comb begin
    m_axis_tdata = '0;
    q_in         = '0;
    for (int k = 0; k < NUM_ELEM; k++) begin
      in_e[k]                   = s_axis_tdata[k*W +: W];
      m_axis_tdata[k*W +: W]    = o_e[k];
      q_in[k*W +: W]            = f_e[k];
      q_in[CO + k*CW +: CW]     = f_cof[k];
      b_e[k]                    = q_out[k*W +: W];
      b_cof[k]                  = q_out[CO + k*CW +: CW];
    end
    q_in[DO +: DW] = f_det;
    q_in[QW-1]     = f_sing;
    b_det          = q_out[DO +: DW];
    b_sing         = q_out[QW-1];
  end

  assign m_axis_tuser = o_sing;

  m3i_front #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_elem_i   (in_e),
    .out_valid_o (f_valid),
    .out_ready_i (f_ready),
    .out_elem_o  (f_e),
    .out_cof_o   (f_cof),
    .out_det_o   (f_det),
    .out_sing_o  (f_sing)
  );

  m3i_queue #(
    .WIDTH (QW),
    .DEPTH (2)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_data_i  (q_in),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_ready),
    .pop_data_o   (q_out)
  );

  m3i_back #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (b_valid),
    .in_ready_o  (b_ready),
    .in_elem_i   (b_e),
    .in_cof_i    (b_cof),
    .in_det_i    (b_det),
    .in_sing_i   (b_sing),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_elem_o  (o_e),
    .out_sing_o  (o_sing)
  );

endmodule
